@@ src/pid_position_incremental_core_assert.svh @@
// Assertion macros shared by the PID controller RTL.
// Included by pid_position_incremental_core.sv; no other dependencies.
`ifndef PID_POSITION_INCREMENTAL_CORE_ASSERT_SVH
`define PID_POSITION_INCREMENTAL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PPI_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ppi_pkg.sv @@
// Package for the PID controller: widths, register indexes and beat types.
// No dependencies; imported by pid_position_incremental_core.
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int DATA_W   = 16;
    localparam int FRAC_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = DATA_W + 1;   // setpoint - measurement
    localparam int DIFF1_W  = DATA_W + 2;   // e - e1
    localparam int DIFF2_W  = DATA_W + 3;   // e - 2*e1 + e2
    localparam int SUM_W    = 21;           // error accumulator
    localparam int ACC_W    = SUM_W + 1;    // accumulator before the clamp
    localparam int OLIM_W   = 15;
    localparam int ILIM_W   = 20;
    localparam int SEP_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Multiplier operand widths: each covers both modes.
    localparam int OPP_W  = DIFF1_W;
    localparam int OPI_W  = (SUM_W > ERR_W) ? SUM_W : ERR_W;
    localparam int OPD_W  = DIFF2_W;
    localparam int PRODP_W = GAIN_W + OPP_W;
    localparam int PRODI_W = GAIN_W + OPI_W;
    localparam int PRODD_W = GAIN_W + OPD_W;
    localparam int RAW_W   = PRODI_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_THR   = 3'd6;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam logic [ILIM_W-1:0] INT_LIMIT_RESET = 20'd10000;
    localparam logic [SEP_W-1:0]  SEP_THR_RESET   = 16'd100;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measurement;
        logic                     restart;
    } pid_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     saturated;
    } pid_out_t;

endpackage

@@ src/pid_position_incremental_core.sv @@
// PID controller, positional and incremental modes, one sample per cycle unless stalled.
// Depends on ppi_pkg and pid_position_incremental_core_assert.svh.
//
// Usage:
// - Input channel s_valid/s_ready/s_data carries one sample per beat:
//   setpoint, measurement and a restart flag that clears the history,
//   accumulator and previous drive before the sample is used.
// - Result channel m_valid/m_ready/m_data returns one beat per sample:
//   the drive value clamped to +/- output_limit and a saturation flag.
// - Configuration: cfg_we writes cfg_data to register cfg_index at the
//   clock edge; write only while no sample is in flight.
// - The sample register feeds one pass of error, accumulator clamp, three gain
//   multipliers, a sum and the output clamp into the result register, which
//   drives m_valid and m_data.
// - One sample per cycle unless a result waits on low m_ready; controller state
//   updates as each result is registered, so the next sample sees it at once.
// - When m_ready is low and a result waits, the result register holds; the sample
//   register takes a beat only if empty, and s_ready is low until the result moves.
// - Reset (aresetn low, synchronous) empties both registers, zeroes the
//   controller state and loads the register defaults.
`timescale 1ns / 1ps

module pid_position_incremental_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ppi_pkg::pid_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ppi_pkg::pid_out_t                  m_data,
    input  logic                               cfg_we,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ppi_pkg::*;

    // Configuration registers.
    logic                     mode_reg;
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [OLIM_W-1:0]        out_limit_reg;
    logic [ILIM_W-1:0]        int_limit_reg;
    logic [SEP_W-1:0]         sep_thr_reg;

    // Controller state.
    logic signed [ERR_W-1:0]  prev_error_reg,      prev_error_next;
    logic signed [ERR_W-1:0]  prev_prev_error_reg, prev_prev_error_next;
    logic signed [SUM_W-1:0]  error_sum_reg,       error_sum_next;
    logic signed [DATA_W-1:0] prev_drive_reg;

    // Sample and result registers.
    logic     in_valid_reg;
    pid_in_t  in_reg;
    logic     out_valid_reg;
    pid_out_t out_reg, out_next;

    logic advance;

    logic signed [ERR_W-1:0]   e1, e2, err;
    logic signed [SUM_W-1:0]   sum_old;
    logic signed [DATA_W-1:0]  drv_old;
    logic [ERR_W-1:0]          err_mag;
    logic signed [DIFF1_W-1:0] diff1;
    logic signed [DIFF2_W-1:0] diff2;
    logic signed [ACC_W-1:0]   acc, ilim;
    logic signed [SUM_W-1:0]   acc_clamped;
    logic signed [OPP_W-1:0]   op_p;
    logic signed [OPI_W-1:0]   op_i;
    logic signed [OPD_W-1:0]   op_d;
    logic signed [PRODP_W-1:0] prod_p;
    logic signed [PRODI_W-1:0] prod_i;
    logic signed [PRODD_W-1:0] prod_d;
    logic signed [RAW_W-1:0]   raw, olim;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_POSITIONAL;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            out_limit_reg <= '0;
            int_limit_reg <= INT_LIMIT_RESET;
            sep_thr_reg   <= SEP_THR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= cfg_data[0];
                CFG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                CFG_OUT_LIMIT: out_limit_reg <= cfg_data[OLIM_W-1:0];
                CFG_INT_LIMIT: int_limit_reg <= cfg_data[ILIM_W-1:0];
                CFG_SEP_THR:   sep_thr_reg   <= cfg_data[SEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // A restart beat runs against cleared history.
        e1      = in_reg.restart ? '0 : prev_error_reg;
        e2      = in_reg.restart ? '0 : prev_prev_error_reg;
        sum_old = in_reg.restart ? '0 : error_sum_reg;
        drv_old = in_reg.restart ? '0 : prev_drive_reg;

        err     = ERR_W'(in_reg.setpoint) - ERR_W'(in_reg.measurement);
        err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        diff1   = DIFF1_W'(err) - DIFF1_W'(e1);
        diff2   = DIFF2_W'(err) - (DIFF2_W'(e1) <<< 1) + DIFF2_W'(e2);

        // Accumulator: add, clamp, then integral separation.
        acc  = ACC_W'(sum_old) + ACC_W'(err);
        ilim = ACC_W'({2'b00, int_limit_reg});
        if (acc > ilim) begin
            acc_clamped = SUM_W'(ilim);
        end else if (acc < -ilim) begin
            acc_clamped = SUM_W'(-ilim);
        end else begin
            acc_clamped = SUM_W'(acc);
        end
        if (err_mag > ERR_W'(sep_thr_reg)) begin
            acc_clamped = '0;
        end

        if (mode_reg == MODE_INCREMENTAL) begin
            error_sum_next = sum_old;
            op_p = OPP_W'(diff1);
            op_i = OPI_W'(err);
            op_d = OPD_W'(diff2);
        end else begin
            error_sum_next = acc_clamped;
            op_p = OPP_W'(err);
            op_i = OPI_W'(acc_clamped);
            op_d = OPD_W'(diff1);
        end

        prod_p = PRODP_W'(gain_p_reg) * op_p;
        prod_i = PRODI_W'(gain_i_reg) * op_i;
        prod_d = PRODD_W'(gain_d_reg) * op_d;

        // Arithmetic shifts give the floor of each product of a Q8.8 gain.
        raw = RAW_W'(prod_p >>> FRAC_W) + RAW_W'(prod_i >>> FRAC_W)
            + RAW_W'(prod_d >>> FRAC_W);
        if (mode_reg == MODE_INCREMENTAL) begin
            raw = raw + RAW_W'(drv_old);
        end

        olim = RAW_W'({1'b0, out_limit_reg});
        if (raw > olim) begin
            out_next.drive     = DATA_W'(olim);
            out_next.saturated = 1'b1;
        end else if (raw < -olim) begin
            out_next.drive     = DATA_W'(-olim);
            out_next.saturated = 1'b1;
        end else begin
            out_next.drive     = DATA_W'(raw);
            out_next.saturated = 1'b0;
        end

        prev_error_next      = err;
        prev_prev_error_next = e1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
            error_sum_reg       <= '0;
            prev_drive_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg       <= 1'b1;
                prev_error_reg      <= prev_error_next;
                prev_prev_error_reg <= prev_prev_error_next;
                error_sum_reg       <= error_sum_next;
                prev_drive_reg      <= out_next.drive;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

`include "pid_position_incremental_core_assert.svh"

    `PPI_ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance, out_valid_reg,
        "result beat not registered")

    `PPI_ASSERT_NEXT(a_prev_drive_tracks, aclk, aresetn, advance,
        prev_drive_reg == out_reg.drive, "previous drive differs from the last result")

    `PPI_ASSERT_NEXT(a_history_shift, aclk, aresetn, advance && !in_reg.restart,
        prev_prev_error_reg == $past(prev_error_reg), "error history did not shift")

    `PPI_ASSERT_NEXT(a_incr_sum_hold, aclk, aresetn,
        advance && !in_reg.restart && mode_reg == MODE_INCREMENTAL,
        $stable(error_sum_reg), "accumulator moved in incremental mode")

    `PPI_ASSERT_NEXT(a_sum_bound, aclk, aresetn,
        advance && !cfg_we && mode_reg == MODE_POSITIONAL,
        (ACC_W'(error_sum_reg) <= ilim) && (ACC_W'(error_sum_reg) >= -ilim),
        "accumulator outside integral limit")

endmodule

@@ dv/pid_drive_scoreboard_pkg.sv @@
// Scoreboard for the PID controller: keeps its own copy of the registers and
// controller state, predicts the drive beat for each sample and checks results.
// Depends on ppi_pkg for widths, register indexes, mode codes and beat types.
`timescale 1ns / 1ps

package pid_drive_scoreboard_pkg;

    import ppi_pkg::*;

    class pid_drive_scoreboard;

        logic                      mode;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [OLIM_W-1:0]         out_limit;
        logic [ILIM_W-1:0]         int_limit;
        logic [SEP_W-1:0]          sep_thr;

        logic signed [ERR_W-1:0]   prev_err;
        logic signed [ERR_W-1:0]   prev_prev_err;
        logic signed [SUM_W-1:0]   err_sum;
        logic signed [DATA_W-1:0]  last_drive;

        pid_out_t                  drive_expected[$];
        int                        errors;

        function new();
            mode          = MODE_POSITIONAL;
            gain_p        = '0;
            gain_i        = '0;
            gain_d        = '0;
            out_limit     = '0;
            int_limit     = INT_LIMIT_RESET;
            sep_thr       = SEP_THR_RESET;
            prev_err      = '0;
            prev_prev_err = '0;
            err_sum       = '0;
            last_drive    = '0;
            errors        = 0;
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim) begin
                return lim;
            end
            if (v < -lim) begin
                return -lim;
            end
            return v;
        endfunction

        // Arithmetic shift of a signed value rounds toward minus infinity.
        function longint floor_q(longint v);
            return v >>> FRAC_W;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:      mode      = data[0];
                CFG_GAIN_P:    gain_p    = data[GAIN_W-1:0];
                CFG_GAIN_I:    gain_i    = data[GAIN_W-1:0];
                CFG_GAIN_D:    gain_d    = data[GAIN_W-1:0];
                CFG_OUT_LIMIT: out_limit = data[OLIM_W-1:0];
                CFG_INT_LIMIT: int_limit = data[ILIM_W-1:0];
                CFG_SEP_THR:   sep_thr   = data[SEP_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(pid_in_t smp);
            longint   err;
            longint   mag;
            longint   acc;
            longint   raw;
            longint   drv;
            longint   e1;
            longint   e2;
            pid_out_t exp_beat;

            if (smp.restart) begin
                prev_err      = '0;
                prev_prev_err = '0;
                err_sum       = '0;
                last_drive    = '0;
            end

            err = longint'($signed(smp.setpoint)) - longint'($signed(smp.measurement));
            mag = (err < 0) ? -err : err;
            e1  = longint'(prev_err);
            e2  = longint'(prev_prev_err);

            if (mode == MODE_POSITIONAL) begin
                // The accumulator is clamped first, then cleared on a large error.
                acc = clamp_sym(longint'(err_sum) + err, longint'(int_limit));
                if (mag > longint'(sep_thr)) begin
                    acc = 0;
                end
                err_sum = acc[SUM_W-1:0];
                raw = floor_q(longint'(gain_p) * err)
                    + floor_q(longint'(gain_d) * (err - e1))
                    + floor_q(longint'(gain_i) * acc);
            end else begin
                raw = longint'(last_drive)
                    + floor_q(longint'(gain_p) * (err - e1))
                    + floor_q(longint'(gain_i) * err)
                    + floor_q(longint'(gain_d) * (err - 2 * e1 + e2));
            end

            drv = clamp_sym(raw, longint'(out_limit));

            prev_prev_err = prev_err;
            prev_err      = err[ERR_W-1:0];
            last_drive    = drv[DATA_W-1:0];

            exp_beat.drive     = drv[DATA_W-1:0];
            exp_beat.saturated = (drv != raw);
            drive_expected.push_back(exp_beat);
        endfunction

        function void check_drive(pid_out_t got);
            pid_out_t exp_beat;
            if (drive_expected.size() == 0) begin
                $error("result beat with no sample pending: drive %0d saturated %0b",
                       $signed(got.drive), got.saturated);
                errors++;
                return;
            end
            exp_beat = drive_expected.pop_front();
            if (got.drive !== exp_beat.drive) begin
                $error("drive mismatch: expected %0d, actual %0d",
                       $signed(exp_beat.drive), $signed(got.drive));
                errors++;
            end
            if (got.saturated !== exp_beat.saturated) begin
                $error("saturated mismatch: expected %0b, actual %0b",
                       exp_beat.saturated, got.saturated);
                errors++;
            end
        endfunction

        function int pending();
            return drive_expected.size();
        endfunction

    endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench for pid_position_incremental_core: directed samples,
// then randomized configuration phases with random idling and backpressure.
// Depends on ppi_pkg, pid_drive_scoreboard_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    import ppi_pkg::*;
    import pid_drive_scoreboard_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    pid_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    pid_out_t              m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pid_drive_scoreboard   sb = new();

    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    hold_long;
    logic [DATA_W-1:0]     target_sp;
    int                    spread;

    always #5 aclk = ~aclk;

    pid_position_incremental_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Everything that crosses a port is observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.take_sample(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_drive(m_data);
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_long = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic pid_in_t mk(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] meas,
                                   input logic rst);
        pid_in_t smp;
        smp.setpoint    = sp;
        smp.measurement = meas;
        smp.restart     = rst;
        return smp;
    endfunction

    // Mostly a held setpoint with the measurement tracking it closely, so the
    // accumulator actually builds up; now and then a wild measurement.
    function automatic pid_in_t next_sample();
        pid_in_t smp;
        int      delta;
        if ($urandom_range(0, 9) == 0) begin
            target_sp = DATA_W'($urandom);
        end
        smp.setpoint = target_sp;
        if ($urandom_range(0, 9) == 0) begin
            smp.measurement = DATA_W'($urandom);
        end else begin
            delta = int'($urandom_range(0, 2 * spread)) - spread;
            smp.measurement = target_sp - DATA_W'(delta);
        end
        smp.restart = ($urandom_range(0, 31) == 0);
        return smp;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return GAIN_W'($urandom_range(0, 16'h0600) - 16'h0300);
        endcase
    endfunction

    // Entered and left at a falling edge; valid is lowered only for a gap,
    // so back-to-back beats keep it high.
    task automatic send_sample(input pid_in_t smp);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
    endtask

    task automatic load_config(input logic md, input logic [GAIN_W-1:0] kp,
                               input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                               input logic [OLIM_W-1:0] olim, input logic [ILIM_W-1:0] ilim,
                               input logic [SEP_W-1:0] sep);
        put_reg(CFG_MODE,      CFG_DATA_W'(md));
        put_reg(CFG_GAIN_P,    CFG_DATA_W'(kp));
        put_reg(CFG_GAIN_I,    CFG_DATA_W'(ki));
        put_reg(CFG_GAIN_D,    CFG_DATA_W'(kd));
        put_reg(CFG_OUT_LIMIT, CFG_DATA_W'(olim));
        put_reg(CFG_INT_LIMIT, CFG_DATA_W'(ilim));
        put_reg(CFG_SEP_THR,   CFG_DATA_W'(sep));
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items, input bit mid_drain);
        logic              md;
        logic [OLIM_W-1:0] olim;
        logic [ILIM_W-1:0] ilim;
        logic [SEP_W-1:0]  sep;
        md = $urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL;
        case ($urandom_range(0, 9))
            0:       olim = '0;
            1:       olim = '1;
            default: olim = OLIM_W'($urandom_range(1, 5000));
        endcase
        case ($urandom_range(0, 9))
            0:       ilim = '0;
            1:       ilim = '1;
            default: ilim = ILIM_W'($urandom_range(1, 20000));
        endcase
        case ($urandom_range(0, 9))
            0:       sep = '0;
            1:       sep = '1;
            default: sep = SEP_W'($urandom_range(1, 2000));
        endcase
        load_config(md, rand_gain(), rand_gain(), rand_gain(), olim, ilim, sep);
        spread = (int'(sep) > 3000) ? 3000 : int'(sep) + 2;
        for (int i = 0; i < n_items; i++) begin
            if (mid_drain && i == n_items / 2) begin
                drain();
            end
            send_sample(next_sample());
        end
        drain();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_long  = 1'b0;
        target_sp  = '0;
        spread     = 100;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults: zero gains and zero output limit give a zero drive.
        send_sample(mk(16'd1000, -16'sd2000, 1'b0));
        send_sample(mk(-16'sd5, 16'd7, 1'b1));
        drain();

        // Positional: accumulator clamps on both sides, an error exactly at the
        // threshold keeps it, one step above clears it.
        load_config(MODE_POSITIONAL, 16'h0100, 16'h0080, 16'hFFC0, 15'h7FFF, 20'd120, 16'd100);
        send_sample(mk(16'd50, 16'd0, 1'b0));
        send_sample(mk(16'd50, 16'd0, 1'b0));
        send_sample(mk(16'd50, 16'd0, 1'b0));
        send_sample(mk(16'd0, -16'sd100, 1'b0));
        send_sample(mk(16'd101, 16'd0, 1'b0));
        send_sample(mk(-16'sd90, 16'd0, 1'b0));
        send_sample(mk(-16'sd90, 16'd0, 1'b0));
        send_sample(mk(16'h7FFF, 16'h8000, 1'b0));
        send_sample(mk(16'h8000, 16'h7FFF, 1'b0));
        send_sample(mk(16'd20, 16'd0, 1'b1));
        drain();

        load_config(MODE_INCREMENTAL, 16'h0200, 16'h0040, 16'h0100, 15'd1000, 20'd10000,
                    16'd100);
        send_sample(mk(16'd10, 16'd0, 1'b1));
        send_sample(mk(16'd30, 16'd0, 1'b0));
        send_sample(mk(-16'sd20, 16'd5, 1'b0));
        send_sample(mk(16'h7FFF, 16'h8000, 1'b0));
        send_sample(mk(16'h8000, 16'h7FFF, 1'b0));
        send_sample(mk(16'd0, 16'd0, 1'b0));
        drain();

        // Zero output limit: any nonzero unclamped value only raises the flag.
        load_config(MODE_POSITIONAL, 16'h7FFF, 16'h8000, 16'h0000, 15'd0, 20'd10000, 16'd100);
        send_sample(mk(16'd0, 16'd0, 1'b1));
        send_sample(mk(16'd3, 16'd0, 1'b0));
        send_sample(mk(-16'sd1, 16'd0, 1'b0));
        drain();

        // Mode change without a restart picks up the history left behind.
        load_config(MODE_INCREMENTAL, 16'h0100, 16'h0100, 16'h0100, 15'h7FFF, 20'hFFFFF,
                    16'hFFFF);
        send_sample(mk(16'd7, 16'd2, 1'b0));
        send_sample(mk(-16'sd4, 16'd4, 1'b0));
        drain();

        for (int ph = 0; ph < 20; ph++) begin
            tx_idle_on = (ph < 17) && (ph != 10);
            rx_idle_on = (ph < 17) && (ph != 10);
            if (ph == 4) begin
                hold_long = 1'b1;
            end
            run_random_phase(100, ph == 7);
        end

        repeat (10) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
